// ----- hdl/uvs_pkg.sv -----
// shared types, constants and angle table for the uv sphere vertex generator
package uvs_pkg;

    localparam int DEF_INDEX_BITS = 10;
    localparam int DEF_ANGLE_BITS = 16;
    localparam int FIELD_INDEX_W  = 10;
    localparam int COORD_W        = 32;
    localparam int RADIUS_W       = 31;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int ZW           = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    // reset values of the register file
    localparam logic [FIELD_INDEX_W-1:0] RST_STACK_COUNT = 10'd16;
    localparam logic [FIELD_INDEX_W-1:0] RST_SLICE_COUNT = 10'd16;
    localparam logic [RADIUS_W-1:0]      RST_RADIUS      = 31'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STACK_COUNT = 3'd0,
        CFG_SLICE_COUNT = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_CENTER_X    = 3'd3,
        CFG_CENTER_Y    = 3'd4,
        CFG_CENTER_Z    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [FIELD_INDEX_W-1:0] stack_index;
        logic [FIELD_INDEX_W-1:0] slice_index;
    } request_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } result_t;

endpackage

// ----- hdl/uvs_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module uvs_div
    import uvs_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vld_in,
    input  logic [INDEX_BITS+ANGLE_BITS-1:0] num,
    input  logic [INDEX_BITS-1:0]            den,
    output logic                             vld_out,
    output logic [ANGLE_BITS:0]              quo
);

    localparam int NW = INDEX_BITS + ANGLE_BITS;
    localparam int QW = ANGLE_BITS + 1;

    logic                  vld_reg [1:QW];
    logic [QW-1:0]         quo_reg [1:QW];
    logic [INDEX_BITS-1:0] rem_reg [1:QW-1];
    logic [INDEX_BITS-1:0] den_reg [1:QW-1];
    logic [NW-1:0]         num_reg [1:QW-1];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic                  vld_src;
        logic [QW-1:0]         quo_src;
        logic [INDEX_BITS-1:0] rem_src;
        logic [INDEX_BITS-1:0] den_src;
        logic [NW-1:0]         num_src;
        logic [INDEX_BITS:0]   trial;
        logic                  ge;
        logic [QW-1:0]         quo_next;

        if (j == 0)
        begin : g_first
            // quotient is known to fit in QW bits, so the top bits start below den
            assign vld_src = vld_in;
            assign quo_src = '0;
            assign rem_src = INDEX_BITS'(num >> QW);
            assign den_src = den;
            assign num_src = num;
        end
        else
        begin : g_next
            assign vld_src = vld_reg[j];
            assign quo_src = quo_reg[j];
            assign rem_src = rem_reg[j];
            assign den_src = den_reg[j];
            assign num_src = num_reg[j];
        end

        assign trial    = {rem_src, num_src[ANGLE_BITS-j]};
        assign ge       = trial >= {1'b0, den_src};
        assign quo_next = quo_src | (QW'(ge) << (ANGLE_BITS - j));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else
                vld_reg[j+1] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[j+1] <= quo_next;
        end

        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j+1] <= ge ? INDEX_BITS'(trial - {1'b0, den_src})
                                   : trial[INDEX_BITS-1:0];
                den_reg[j+1] <= den_src;
                num_reg[j+1] <= num_src;
            end
        end
    end

    assign vld_out = vld_reg[QW];
    assign quo     = quo_reg[QW];

endmodule

// ----- hdl/uvs_cordic.sv -----
// pipelined rotation-mode cordic, one iteration per stage
module uvs_cordic
    import uvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      vld_in,
    input  logic [31:0]               angle,
    output logic                      vld_out,
    output logic signed [COORD_W-1:0] cos_out,
    output logic signed [COORD_W-1:0] sin_out
);

    logic                       vld_reg  [0:CORDIC_STEPS];
    logic                       flip_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg    [0:CORDIC_STEPS];
    logic signed [ZW-1:0]       z_reg    [0:CORDIC_STEPS-1];
    logic                       vld_out_reg;
    logic signed [COORD_W-1:0]  cos_reg;
    logic signed [COORD_W-1:0]  sin_reg;

    logic        flip;
    logic [31:0] ang_fold;

    // second and third quadrants rotate by half a turn and negate at the end
    assign flip     = angle[31] ^ angle[30];
    assign ang_fold = {angle[31] ^ flip, angle[30:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        flip_reg[0] <= flip;
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= ZW'($signed(ang_fold));
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [ZW-1:0]       atan_z;
        logic                       pos;

        assign dx     = y_reg[i] >>> i;
        assign dy     = x_reg[i] >>> i;
        assign atan_z = $signed({1'b0, ATAN_TURN[i]});
        assign pos    = ~z_reg[i][ZW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= flip_reg[i];
            x_reg[i+1]    <= pos ? x_reg[i] - dx : x_reg[i] + dx;
            y_reg[i+1]    <= pos ? y_reg[i] + dy : y_reg[i] - dy;
        end

        if (i < CORDIC_STEPS - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                z_reg[i+1] <= pos ? z_reg[i] - atan_z : z_reg[i] + atan_z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else
            vld_out_reg <= vld_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= COORD_W'(flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS]
                                                   : x_reg[CORDIC_STEPS]);
        sin_reg <= COORD_W'(flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS]
                                                   : y_reg[CORDIC_STEPS]);
    end

    assign vld_out = vld_out_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// ----- hdl/uvs_scale.sv -----
// unit vector products, radius scaling, center offset and saturation
module uvs_scale
    import uvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      vld_in,
    input  logic signed [COORD_W-1:0] cos_phi,
    input  logic signed [COORD_W-1:0] sin_phi,
    input  logic signed [COORD_W-1:0] cos_theta,
    input  logic signed [COORD_W-1:0] sin_theta,
    input  logic [RADIUS_W-1:0]       radius,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] center_z,
    output logic                      vld_out,
    output result_t                   result
);

    localparam int PW = 2 * COORD_W;
    localparam int SW = PW - 30 + 1;
    localparam logic signed [PW-1:0] HALF_Q30 = PW'(64'sd536870912);

    logic [4:1] vld_reg;

    logic signed [PW-1:0]      ux_prod_reg;
    logic signed [PW-1:0]      uz_prod_reg;
    logic signed [COORD_W-1:0] cp1_reg;
    logic signed [COORD_W-1:0] ux_reg;
    logic signed [COORD_W-1:0] uz_reg;
    logic signed [COORD_W-1:0] cp2_reg;
    logic signed [PW-1:0]      mx_reg;
    logic signed [PW-1:0]      my_reg;
    logic signed [PW-1:0]      mz_reg;
    result_t                   result_reg;

    logic signed [PW-1:0]      ux_rnd;
    logic signed [PW-1:0]      uz_rnd;
    logic signed [COORD_W-1:0] rad_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:1], vld_in};
    end

    assign ux_rnd = ux_prod_reg + HALF_Q30;
    assign uz_rnd = uz_prod_reg + HALF_Q30;
    assign rad_s  = $signed({1'b0, radius});

    function automatic logic signed [COORD_W-1:0] offset_sat(
        input logic signed [PW-1:0]      m,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [PW-1:0] r;
        logic signed [SW-1:0] s;
        r = m + HALF_Q30;
        s = SW'($signed(r[PW-1:30])) + SW'(c);
        // top bits disagree with the sign: clip to the signed range
        if (s[SW-1:COORD_W-1] == '0 || s[SW-1:COORD_W-1] == '1)
            return s[COORD_W-1:0];
        else if (s[SW-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    always_ff @(posedge clk)
    begin
        ux_prod_reg <= cos_theta * sin_phi;
        uz_prod_reg <= sin_theta * sin_phi;
        cp1_reg     <= cos_phi;

        ux_reg  <= ux_rnd[COORD_W+29:30];
        uz_reg  <= uz_rnd[COORD_W+29:30];
        cp2_reg <= cp1_reg;

        mx_reg <= rad_s * ux_reg;
        my_reg <= rad_s * cp2_reg;
        mz_reg <= rad_s * uz_reg;

        result_reg.pos_x <= offset_sat(mx_reg, center_x);
        result_reg.pos_y <= offset_sat(my_reg, center_y);
        result_reg.pos_z <= offset_sat(mz_reg, center_z);
    end

    assign vld_out = vld_reg[4];
    assign result  = result_reg;

endmodule

// ----- hdl/uv_sphere_vertex_gen_top.sv -----
// throughput: one request per cycle, busy never rises; set by the fully pipelined
// dividers (one quotient bit a stage) and the 30-stage cordic units
// results cannot be stalled and leave on done for one cycle each
// reset clears the pipeline valid bits and loads the register defaults
// (16 stacks, 16 slices, radius 1.0, center at the origin)
module uv_sphere_vertex_gen_top
    import uvs_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               request,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   done,
    output result_t                result
);

    localparam int NW  = INDEX_BITS + ANGLE_BITS;
    localparam int LAT = ANGLE_BITS + 38;

    logic [FIELD_INDEX_W-1:0]  stack_count_reg;
    logic [FIELD_INDEX_W-1:0]  slice_count_reg;
    logic [RADIUS_W-1:0]       radius_reg;
    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic signed [COORD_W-1:0] center_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= RST_STACK_COUNT;
            slice_count_reg <= RST_SLICE_COUNT;
            radius_reg      <= RST_RADIUS;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STACK_COUNT: stack_count_reg <= cfg_data[FIELD_INDEX_W-1:0];
                CFG_SLICE_COUNT: slice_count_reg <= cfg_data[FIELD_INDEX_W-1:0];
                CFG_RADIUS:      radius_reg      <= cfg_data[RADIUS_W-1:0];
                CFG_CENTER_X:    center_x_reg    <= $signed(cfg_data);
                CFG_CENTER_Y:    center_y_reg    <= $signed(cfg_data);
                CFG_CENTER_Z:    center_z_reg    <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    // front stage: mask, clamp and form the rounded dividends
    logic [15:0]           sc_w, tc_w, s_w, t_w;
    logic [INDEX_BITS-1:0] sc, tc, s_cl, t_cl;

    assign sc_w = 16'(stack_count_reg);
    assign tc_w = 16'(slice_count_reg);
    assign s_w  = 16'(request.stack_index);
    assign t_w  = 16'(request.slice_index);

    always_comb
    begin
        sc   = (sc_w[INDEX_BITS-1:0] == '0) ? INDEX_BITS'(1) : sc_w[INDEX_BITS-1:0];
        tc   = (tc_w[INDEX_BITS-1:0] == '0) ? INDEX_BITS'(1) : tc_w[INDEX_BITS-1:0];
        s_cl = (s_w[INDEX_BITS-1:0] > sc) ? sc : s_w[INDEX_BITS-1:0];
        t_cl = (t_w[INDEX_BITS-1:0] > tc) ? tc : t_w[INDEX_BITS-1:0];
    end

    logic                  front_vld_reg;
    logic [NW-1:0]         phi_num_reg, theta_num_reg;
    logic [INDEX_BITS-1:0] phi_den_reg, theta_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= 1'b0;
        else
            front_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        phi_num_reg   <= (NW'(s_cl) << (ANGLE_BITS - 1)) + NW'(sc >> 1);
        theta_num_reg <= (NW'(t_cl) << ANGLE_BITS) + NW'(tc >> 1);
        phi_den_reg   <= sc;
        theta_den_reg <= tc;
    end

    logic                phi_div_vld, theta_div_vld;
    logic [ANGLE_BITS:0] phi_q, theta_q;

    uvs_div #(.INDEX_BITS(INDEX_BITS), .ANGLE_BITS(ANGLE_BITS)) u_div_phi (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (front_vld_reg),
        .num     (phi_num_reg),
        .den     (phi_den_reg),
        .vld_out (phi_div_vld),
        .quo     (phi_q)
    );

    uvs_div #(.INDEX_BITS(INDEX_BITS), .ANGLE_BITS(ANGLE_BITS)) u_div_theta (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (front_vld_reg),
        .num     (theta_num_reg),
        .den     (theta_den_reg),
        .vld_out (theta_div_vld),
        .quo     (theta_q)
    );

    // binary angle to a 32-bit full turn, the seam wraps to zero
    logic [31:0] phi_turn, theta_turn;

    assign phi_turn   = {phi_q[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    assign theta_turn = {theta_q[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

    logic                      phi_cs_vld, theta_cs_vld;
    logic signed [COORD_W-1:0] cos_phi, sin_phi, cos_theta, sin_theta;

    uvs_cordic u_cordic_phi (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (phi_div_vld),
        .angle   (phi_turn),
        .vld_out (phi_cs_vld),
        .cos_out (cos_phi),
        .sin_out (sin_phi)
    );

    uvs_cordic u_cordic_theta (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (theta_div_vld),
        .angle   (theta_turn),
        .vld_out (theta_cs_vld),
        .cos_out (cos_theta),
        .sin_out (sin_theta)
    );

    uvs_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (phi_cs_vld),
        .cos_phi   (cos_phi),
        .sin_phi   (sin_phi),
        .cos_theta (cos_theta),
        .sin_theta (sin_theta),
        .radius    (radius_reg),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .vld_out   (done),
        .result    (result)
    );

    // both angle paths must stay in lock step
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        phi_div_vld == theta_div_vld)
        else $error("angle dividers out of step");

    a_cordic_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        phi_cs_vld == theta_cs_vld)
        else $error("cordic units out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching request");

endmodule
